[rtl/core/acf_pkg.sv]
package acf_pkg;

  // Field and datapath widths
  localparam int IN_W     = 144;
  localparam int OUT_W    = 96;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 24;
  localparam int STEP_W   = 5;
  localparam int MA_W     = 35;   // multiplier A side, signed
  localparam int MB_W     = 25;   // multiplier B side, signed
  localparam int PROD_W   = MA_W + MB_W;
  localparam int ACC_W    = 64;

  localparam logic [STEP_W-1:0] LAST_STEP = 5'd29;

  // Register reset values
  localparam logic [20:0] GRAVITY_RST     = 21'd642908;
  localparam logic [23:0] TIME_STEP_RST   = 24'd33554;
  localparam logic [15:0] TICK_RATE_RST   = 16'd500;
  localparam logic [15:0] HEIGHT_GAIN_RST = 16'd19661;
  localparam logic [15:0] SPEED_GAIN_RST  = 16'd655;

  // One g at Q.28, removed before the gravity scaling
  localparam logic signed [ACC_W-1:0] ZQ_ONE  = 64'sd268435456;
  localparam logic signed [ACC_W-1:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -64'sd2147483648;

  typedef enum logic [CFG_AW-1:0] {
    REG_GRAVITY, REG_TIME_STEP, REG_TICK_RATE, REG_HEIGHT_GAIN, REG_SPEED_GAIN
  } reg_idx_t;

  // First field in the lowest bits, so members run from the top down
  typedef struct packed {
    logic signed [31:0] baro_alt;
    logic signed [15:0] roll_cosine;
    logic signed [15:0] roll_sine;
    logic signed [15:0] pitch_cosine;
    logic signed [15:0] pitch_sine;
    logic signed [15:0] accel_z;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_x;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vertical_accel;
    logic signed [31:0] climb_rate;
    logic signed [31:0] height;
  } out_item_t;

  typedef struct packed {
    logic [20:0] gravity;
    logic [23:0] time_step;
    logic [15:0] tick_rate;
    logic [15:0] height_gain;
    logic [15:0] speed_gain;
  } cfg_t;

  // Microcode fields
  typedef enum logic [1:0] {COND_NONE, COND_WAIT_IN, COND_WAIT_OUT} cond_t;
  typedef enum logic [2:0] {A_AX, A_AY, A_AZ, A_TMP, A_VACC, A_SPRED} asel_t;
  typedef enum logic [3:0] {
    B_PS, B_PC, B_RS, B_RC, B_GRAV, B_TSTEP, B_HGAIN, B_RATE, B_SGAIN
  } bsel_t;
  typedef enum logic [2:0] {
    ALU_NOP, ALU_RND, ALU_ACC_ADD, ALU_TMP_LD, ALU_TMP_BIAS, ALU_TMP_SUB, ALU_ADD_SAT
  } alu_t;
  typedef enum logic [2:0] {SH_0, SH_14, SH_16, SH_24, SH_28} shift_t;
  typedef enum logic [3:0] {
    R_ZERO, R_BARO, R_VACC, R_SPRED, R_HPRED, R_HNEW, R_SMEAS, R_FSPEED, R_FHEIGHT
  } rsel_t;

  typedef struct packed {
    cond_t             cond;
    logic              jump;
    logic [STEP_W-1:0] target;
    logic              mul_en;
    asel_t             a_sel;
    bsel_t             b_sel;
    alu_t              alu;
    shift_t            shift;
    rsel_t             src_x;
    rsel_t             src_y;
    rsel_t             dst;
  } ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = 32'sh7fffffff;
    else if (v < SAT_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Microprogram. The multiplier result lands one step after its launch,
  // so a step may launch a product while the ALU consumes the previous one.
  function automatic ctl_t acf_ucode(input logic [STEP_W-1:0] pc);
    ctl_t w;
    w = '0;
    case (pc)
      5'd0: w.cond = COND_WAIT_IN;
      // vertical g: (ay*rs + az*rc)*pc rounded, plus ax*ps
      5'd1: begin w.mul_en = 1'b1; w.a_sel = A_AY; w.b_sel = B_RS; end
      5'd2: begin
        w.mul_en = 1'b1; w.a_sel = A_AZ; w.b_sel = B_RC;
        w.alu = ALU_RND; w.shift = SH_0;
      end
      5'd3: w.alu = ALU_ACC_ADD;
      5'd4: w.alu = ALU_TMP_LD;
      5'd5: begin w.mul_en = 1'b1; w.a_sel = A_TMP; w.b_sel = B_PC; end
      5'd6: begin
        w.mul_en = 1'b1; w.a_sel = A_AX; w.b_sel = B_PS;
        w.alu = ALU_RND; w.shift = SH_14;
      end
      5'd7: w.alu = ALU_ACC_ADD;
      // acceleration minus gravity
      5'd8: w.alu = ALU_TMP_BIAS;
      5'd9: begin w.mul_en = 1'b1; w.a_sel = A_TMP; w.b_sel = B_GRAV; end
      5'd10: begin w.alu = ALU_RND; w.shift = SH_28; end
      5'd11: begin w.alu = ALU_ADD_SAT; w.src_x = R_ZERO; w.dst = R_VACC; end
      // speed prediction
      5'd12: begin w.mul_en = 1'b1; w.a_sel = A_VACC; w.b_sel = B_TSTEP; end
      5'd13: begin w.alu = ALU_RND; w.shift = SH_24; end
      5'd14: begin w.alu = ALU_ADD_SAT; w.src_x = R_FSPEED; w.dst = R_SPRED; end
      // height prediction
      5'd15: begin w.mul_en = 1'b1; w.a_sel = A_SPRED; w.b_sel = B_TSTEP; end
      5'd16: begin w.alu = ALU_RND; w.shift = SH_24; end
      5'd17: begin w.alu = ALU_ADD_SAT; w.src_x = R_FHEIGHT; w.dst = R_HPRED; end
      // blend toward baro height
      5'd18: begin w.alu = ALU_TMP_SUB; w.src_x = R_BARO; w.src_y = R_HPRED; end
      5'd19: begin w.mul_en = 1'b1; w.a_sel = A_TMP; w.b_sel = B_HGAIN; end
      5'd20: begin w.alu = ALU_RND; w.shift = SH_16; end
      5'd21: begin w.alu = ALU_ADD_SAT; w.src_x = R_HPRED; w.dst = R_HNEW; end
      // measured speed from height difference
      5'd22: begin w.alu = ALU_TMP_SUB; w.src_x = R_HNEW; w.src_y = R_FHEIGHT; end
      5'd23: begin w.mul_en = 1'b1; w.a_sel = A_TMP; w.b_sel = B_RATE; end
      5'd24: begin w.alu = ALU_RND; w.shift = SH_0; end
      5'd25: begin w.alu = ALU_ADD_SAT; w.src_x = R_ZERO; w.dst = R_SMEAS; end
      // blend toward measured speed, then hand off the result
      5'd26: begin w.alu = ALU_TMP_SUB; w.src_x = R_SMEAS; w.src_y = R_SPRED; end
      5'd27: begin w.mul_en = 1'b1; w.a_sel = A_TMP; w.b_sel = B_SGAIN; end
      5'd28: begin w.alu = ALU_RND; w.shift = SH_16; end
      5'd29: begin
        w.alu = ALU_ADD_SAT; w.src_x = R_SPRED; w.dst = R_FSPEED;
        w.cond = COND_WAIT_OUT; w.jump = 1'b1; w.target = '0;
      end
      default: begin w.jump = 1'b1; w.target = '0; end
    endcase
    return w;
  endfunction

endpackage

[rtl/core/acf_datapath.sv]
module acf_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  acf_pkg::ctl_t           ctl,
  input  acf_pkg::in_item_t       item,
  input  acf_pkg::cfg_t           cfg,
  output logic signed [31:0]      hnew,
  output logic signed [31:0]      vacc,
  output logic signed [31:0]      sat_res
);
  import acf_pkg::*;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [MA_W-1:0]   tmp_r, tmp_nxt;
  logic signed [ACC_W-1:0]  prod_ext, rnd_res, sum;
  logic signed [31:0]       x_val, y_val;
  logic signed [31:0]       vacc_r, spred_r, hpred_r, hnew_r, smeas_r;
  logic signed [31:0]       fspeed_r, fheight_r;

  // Multiplier operand selection
  always_comb begin
    case (ctl.a_sel)
      A_AX:    mul_a = MA_W'(item.accel_x);
      A_AY:    mul_a = MA_W'(item.accel_y);
      A_AZ:    mul_a = MA_W'(item.accel_z);
      A_TMP:   mul_a = tmp_r;
      A_VACC:  mul_a = MA_W'(vacc_r);
      A_SPRED: mul_a = MA_W'(spred_r);
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctl.b_sel)
      B_PS:    mul_b = MB_W'(item.pitch_sine);
      B_PC:    mul_b = MB_W'(item.pitch_cosine);
      B_RS:    mul_b = MB_W'(item.roll_sine);
      B_RC:    mul_b = MB_W'(item.roll_cosine);
      B_GRAV:  mul_b = MB_W'(cfg.gravity);
      B_TSTEP: mul_b = MB_W'(cfg.time_step);
      B_HGAIN: mul_b = MB_W'(cfg.height_gain);
      B_RATE:  mul_b = MB_W'(cfg.tick_rate);
      B_SGAIN: mul_b = MB_W'(cfg.speed_gain);
      default: mul_b = '0;
    endcase
  end

  // Registered product
  always_ff @(posedge clk) begin
    if (en && ctl.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // Register file reads
  always_comb begin
    case (ctl.src_x)
      R_BARO:    x_val = item.baro_alt;
      R_VACC:    x_val = vacc_r;
      R_SPRED:   x_val = spred_r;
      R_HPRED:   x_val = hpred_r;
      R_HNEW:    x_val = hnew_r;
      R_SMEAS:   x_val = smeas_r;
      R_FSPEED:  x_val = fspeed_r;
      R_FHEIGHT: x_val = fheight_r;
      default:   x_val = '0;
    endcase
  end

  always_comb begin
    case (ctl.src_y)
      R_BARO:    y_val = item.baro_alt;
      R_VACC:    y_val = vacc_r;
      R_SPRED:   y_val = spred_r;
      R_HPRED:   y_val = hpred_r;
      R_HNEW:    y_val = hnew_r;
      R_SMEAS:   y_val = smeas_r;
      R_FSPEED:  y_val = fspeed_r;
      R_FHEIGHT: y_val = fheight_r;
      default:   y_val = '0;
    endcase
  end

  // Round half up: add half an LSB, arithmetic shift
  assign prod_ext = ACC_W'(prod_r);
  always_comb begin
    case (ctl.shift)
      SH_14:   rnd_res = (prod_ext + 64'sd8192) >>> 14;
      SH_16:   rnd_res = (prod_ext + 64'sd32768) >>> 16;
      SH_24:   rnd_res = (prod_ext + 64'sd8388608) >>> 24;
      SH_28:   rnd_res = (prod_ext + 64'sd134217728) >>> 28;
      default: rnd_res = prod_ext;
    endcase
  end

  assign sum     = acc_r + ACC_W'(x_val);
  assign sat_res = sat32(sum);

  // Accumulator and scratch register
  always_comb begin
    acc_nxt = acc_r;
    tmp_nxt = tmp_r;
    case (ctl.alu)
      ALU_RND:      acc_nxt = rnd_res;
      ALU_ACC_ADD:  acc_nxt = acc_r + prod_ext;
      ALU_TMP_LD:   tmp_nxt = acc_r[MA_W-1:0];
      ALU_TMP_BIAS: tmp_nxt = MA_W'(acc_r - ZQ_ONE);
      ALU_TMP_SUB:  tmp_nxt = MA_W'(x_val) - MA_W'(y_val);
      default:      ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      tmp_r <= tmp_nxt;
    end
  end

  // Working registers written by saturating adds
  always_ff @(posedge clk) begin
    if (en && ctl.alu == ALU_ADD_SAT) begin
      case (ctl.dst)
        R_VACC:  vacc_r  <= sat_res;
        R_SPRED: spred_r <= sat_res;
        R_HPRED: hpred_r <= sat_res;
        R_HNEW:  hnew_r  <= sat_res;
        R_SMEAS: smeas_r <= sat_res;
        default: ;
      endcase
    end
  end

  // Filter state; fused height doubles as previous height
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fspeed_r  <= '0;
      fheight_r <= '0;
    end else if (en) begin
      if (ctl.alu == ALU_ADD_SAT && ctl.dst == R_FSPEED) begin
        fspeed_r <= sat_res;
      end
      if (ctl.cond == COND_WAIT_OUT) begin
        fheight_r <= hnew_r;
      end
    end
  end

  assign hnew = hnew_r;
  assign vacc = vacc_r;

endmodule

[rtl/core/altitude_complementary_filter_top.sv]
// Altitude complementary filter.
// Input stream (in_*): one sensor tick per transfer, accel axes, roll and pitch
// trig values and baro height packed in in_tdata. Result stream (out_*): fused
// height, climb rate and vertical acceleration per tick, Q16.16.
// Configuration: write cfg_wdata to register cfg_addr while cfg_we is high
// (gravity, time step, tick rate, height gain, speed gain); only while idle.
// A microcoded sequencer steps a 30-word program through one shared 35x25
// multiplier and a 64-bit accumulator. out_tvalid rises as the sequencer returns
// to its input wait step, and in_tready returns in that same cycle, so a new item
// waits for the whole program. The item rate is set by the program length over the single multiplier.
// The result sits in an output register: the next item is taken and computed
// while it waits. If it is still not taken when the next result is ready, the
// sequencer holds on its last step until out_tready frees the register.
// Reset clears height and speed state, loads register defaults, drops
// out_tvalid and parks the sequencer on its input wait step.
module altitude_complementary_filter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // accel_x, accel_y, accel_z, pitch_sine, pitch_cosine, roll_sine,
  // roll_cosine, baro_alt
  input  logic [acf_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // height, climb_rate, vertical_accel
  output logic [acf_pkg::OUT_W-1:0]     out_tdata,
  input  logic                          cfg_we,
  input  logic [acf_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [acf_pkg::CFG_DW-1:0]    cfg_wdata
);
  import acf_pkg::*;

  cfg_t              cfg_r;
  in_item_t          item_r;
  out_item_t         out_r;
  logic              out_valid_r, out_valid_nxt;
  logic [STEP_W-1:0] pc_r, pc_nxt;
  ctl_t              ctl;
  logic              in_fire, out_free, step_en, out_load;
  logic signed [31:0] hnew, vacc, sat_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gravity     <= GRAVITY_RST;
      cfg_r.time_step   <= TIME_STEP_RST;
      cfg_r.tick_rate   <= TICK_RATE_RST;
      cfg_r.height_gain <= HEIGHT_GAIN_RST;
      cfg_r.speed_gain  <= SPEED_GAIN_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_GRAVITY:     cfg_r.gravity     <= cfg_wdata[20:0];
        REG_TIME_STEP:   cfg_r.time_step   <= cfg_wdata[23:0];
        REG_TICK_RATE:   cfg_r.tick_rate   <= cfg_wdata[15:0];
        REG_HEIGHT_GAIN: cfg_r.height_gain <= cfg_wdata[15:0];
        REG_SPEED_GAIN:  cfg_r.speed_gain  <= cfg_wdata[15:0];
        default:         ;
      endcase
    end
  end

  // Sequencer: fetch, wait conditions, next step
  assign ctl       = acf_ucode(pc_r);
  assign in_tready = (ctl.cond == COND_WAIT_IN);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    case (ctl.cond)
      COND_WAIT_IN:  step_en = in_tvalid;
      COND_WAIT_OUT: step_en = out_free;
      default:       step_en = 1'b1;
    endcase
  end

  assign out_load = (ctl.cond == COND_WAIT_OUT) && step_en;

  always_comb begin
    pc_nxt = pc_r;
    if (step_en) begin
      pc_nxt = ctl.jump ? ctl.target : pc_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item_t'(in_tdata);
    end
  end

  acf_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (step_en),
    .ctl     (ctl),
    .item    (item_r),
    .cfg     (cfg_r),
    .hnew    (hnew),
    .vacc    (vacc),
    .sat_res (sat_res)
  );

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.height         <= hnew;
      out_r.climb_rate     <= sat_res;
      out_r.vertical_accel <= vacc;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  // Checks
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= LAST_STEP)
    else $error("step counter beyond program");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pc_r == STEP_W'(1))
    else $error("program did not start after input transfer");

  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (pc_r == '0) && out_tvalid)
    else $error("result load did not return to input wait");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == LAST_STEP) && out_valid_r && !out_tready |=> pc_r == LAST_STEP)
    else $error("sequencer passed a full output register");

endmodule
